FILE: sv/qsc_pkg.sv
package qsc_pkg;

  localparam int DATA_W = 32;
  localparam int WGT_W = 48;
  localparam int FRAC_W = 17;
  localparam int MODE_W = 2;
  localparam int STEPS = 32;
  localparam logic [DATA_W-1:0] THR_RESET = 32'd3277;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AGGR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RSVD = 2'd3;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_PCT = 2'd1,
    OP_CMP = 2'd2,
    OP_CLR = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_GAP_RD, S_GAP_USE, S_M_RD0, S_M_LD0, S_M_RD, S_M_CHK,
    S_M_MULGO, S_M_MUL, S_M_DIVGO, S_M_DIV, S_M_EMIT, S_M_NEXT, S_M_FIN,
    S_INS_RD, S_INS_USE, S_P_RD, S_P_SUM, S_P_MULGO, S_P_MUL, S_P_WRD,
    S_P_WALK, S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } iter_ctl_t;

endpackage

FILE: sv/quantile_sketch_centroids_core.sv
// Centroid quantile sketch. Pulse start while busy is low; one result word
// comes back with a one-cycle done strobe, which cannot be stalled. Command
// time is set by the single read port of the centroid memories and the shared
// 32-step shift-add unit. A compress merges neighbours, each merge costing a
// divide and, when weighted with a nonzero gap, a multiply; an add into a full
// store in standard or aggressive mode first runs that pass, in aggressive mode
// after a gap scan.
module quantile_sketch_centroids_core import qsc_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      operation,
  input  logic signed [DATA_W-1:0]        sample_value,
  input  logic [DATA_W-1:0]               sample_weight,
  input  logic [FRAC_W-1:0]               rank_fraction,
  output logic                            done,
  output logic signed [DATA_W-1:0]        quantile_value,
  output logic [$clog2(CAPACITY+1)-1:0]   centroid_count,
  output logic                            sample_dropped,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AWD = $clog2(CAPACITY);
  localparam int TW = WGT_W + $clog2(CAPACITY);
  localparam int ACCW = TW + STEPS;

  state_t state, state_next;

  logic [DATA_W-1:0]        thr;
  logic [MODE_W-1:0]        mode;
  op_t                      opr;
  logic signed [DATA_W-1:0] sval;
  logic [WGT_W-1:0]         swgt;
  logic [FRAC_W-1:0]        pfrac;
  logic [CW-1:0]            count, idx, n;
  logic                     weighted;
  logic [DATA_W-1:0]        limit, gap, mean_gap;
  logic signed [DATA_W-1:0] cm, nm;
  logic [WGT_W-1:0]         cw, nw;
  logic [WGT_W:0]           wsum;
  logic                     neg;
  logic [TW-1:0]            total, cum;

  logic                     we;
  logic [AWD-1:0]           waddr, raddr;
  logic [DATA_W-1:0]        wmean;
  logic [WGT_W-1:0]         wwgt;
  logic signed [DATA_W-1:0] rm;
  logic [WGT_W-1:0]         rw;

  iter_ctl_t                ictl;
  logic [TW-1:0]            ia;
  logic [STEPS-1:0]         ib;
  logic                     idone;
  logic [ACCW-1:0]          iacc;
  logic [STEPS-1:0]         iq;

  logic signed [DATA_W:0]   df;
  logic [DATA_W-1:0]        dist_c, gap_c;
  logic [WGT_W:0]           wsum_c;
  logic [TW-1:0]            cum_c;
  logic                     last, full, hit;
  logic [CW-1:0]            idx_m1;
  logic signed [DATA_W+1:0] mg;
  logic [WGT_W-1:0]         wsat;

  qsc_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_mean (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wmean), .raddr(raddr), .rdata(rm)
  );

  qsc_ram #(.WIDTH(WGT_W), .DEPTH(CAPACITY)) u_weight (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wwgt), .raddr(raddr), .rdata(rw)
  );

  qsc_iter #(.AW(TW)) u_iter (
    .clk(clk), .rst(rst), .ctl(ictl), .a(ia), .b(ib), .d(wsum),
    .done(idone), .acc(iacc), .q(iq)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? 32'(mode) : thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
      mode <= MODE_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_THRESHOLD) begin
        thr <= pwdata;
      end else begin
        mode <= pwdata[MODE_W-1:0];
      end
    end
  end

  // shared datapath terms
  always_comb begin
    df = {rm[DATA_W-1], rm} - {cm[DATA_W-1], cm};
    dist_c = df[DATA_W] ? DATA_W'(-df) : df[DATA_W-1:0];
    gap_c = (idx != '0 && dist_c < gap) ? dist_c : gap;
    wsum_c = {1'b0, cw} + {1'b0, rw};
    cum_c = cum + TW'(rw);
    hit = ACCW'({cum_c, 16'h0}) >= iacc;
    last = (idx + 1'b1) == count;
    full = count >= CW'(CAPACITY);
    idx_m1 = idx - 1'b1;
    if (neg) begin
      mg = {{2{cm[DATA_W-1]}}, cm} - $signed({2'b00, iq})
           - $signed((DATA_W+2)'(iacc != '0));
    end else begin
      mg = {{2{cm[DATA_W-1]}}, cm} + $signed({2'b00, iq});
    end
    wsat = wsum[WGT_W] ? {WGT_W{1'b1}} : wsum[WGT_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (op_t'(operation))
            OP_ADD: begin
              if (!full || mode == MODE_NONE || mode == MODE_RSVD) begin
                state_next = S_INS_RD;
              end else if (mode == MODE_STD) begin
                state_next = S_M_RD0;
              end else begin
                state_next = S_GAP_RD;
              end
            end
            OP_PCT: state_next = (count == '0) ? S_DONE : S_P_RD;
            OP_CMP: state_next = (count < CW'(2)) ? S_DONE : S_M_RD0;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_GAP_RD: state_next = S_GAP_USE;
      S_GAP_USE: state_next = last ? S_M_RD0 : S_GAP_RD;
      S_M_RD0: state_next = S_M_LD0;
      S_M_LD0: state_next = S_M_RD;
      S_M_RD: state_next = S_M_CHK;
      S_M_CHK: begin
        if (!weighted) begin
          state_next = (dist_c <= limit) ? S_M_DIVGO : S_M_EMIT;
        end else if (dist_c == '0) begin
          state_next = S_M_DIVGO;
        end else if (wsum_c[WGT_W:DATA_W] != '0) begin
          state_next = S_M_EMIT;
        end else begin
          state_next = S_M_MULGO;
        end
      end
      S_M_MULGO: state_next = S_M_MUL;
      S_M_MUL: begin
        if (idone) begin
          state_next = (iacc <= ACCW'(limit)) ? S_M_DIVGO : S_M_EMIT;
        end
      end
      S_M_DIVGO: state_next = S_M_DIV;
      S_M_DIV: state_next = idone ? S_M_NEXT : S_M_DIV;
      S_M_EMIT: state_next = S_M_NEXT;
      S_M_NEXT: state_next = last ? S_M_FIN : S_M_RD;
      S_M_FIN: state_next = (opr == OP_ADD) ? S_INS_RD : S_DONE;
      S_INS_RD: state_next = (full || idx == '0) ? S_DONE : S_INS_USE;
      S_INS_USE: state_next = (rm >= sval) ? S_INS_RD : S_DONE;
      S_P_RD: state_next = S_P_SUM;
      S_P_SUM: state_next = last ? S_P_MULGO : S_P_RD;
      S_P_MULGO: state_next = S_P_MUL;
      S_P_MUL: state_next = idone ? S_P_WRD : S_P_MUL;
      S_P_WRD: state_next = S_P_WALK;
      S_P_WALK: state_next = (last || hit) ? S_DONE : S_P_WRD;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory and shared unit controls
  always_comb begin
    we = 1'b0;
    waddr = n[AWD-1:0];
    wmean = cm;
    wwgt = cw;
    raddr = idx[AWD-1:0];
    ictl = '0;
    ia = TW'(wsum);
    ib = mean_gap;
    busy = state != S_IDLE;
    done = state == S_DONE;
    case (state)
      S_M_RD0: raddr = '0;
      S_M_MULGO: ictl.start = 1'b1;
      S_M_DIVGO: begin
        ictl.start = 1'b1;
        ictl.is_div = 1'b1;
        ia = TW'(nw);
      end
      S_M_EMIT, S_M_FIN: we = 1'b1;
      S_INS_RD: begin
        raddr = idx_m1[AWD-1:0];
        waddr = '0;
        wmean = sval;
        wwgt = swgt;
        we = !full && idx == '0;
      end
      S_INS_USE: begin
        we = 1'b1;
        waddr = idx[AWD-1:0];
        if (rm >= sval) begin
          wmean = rm;
          wwgt = rw;
        end else begin
          wmean = sval;
          wwgt = swgt;
        end
      end
      S_P_MULGO: begin
        ictl.start = 1'b1;
        ia = total;
        ib = STEPS'(pfrac);
      end
      default: ;
    endcase
  end

  // hold the state register and the centroid count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (start && op_t'(operation) == OP_CLR) count <= '0;
        S_M_FIN: count <= n + 1'b1;
        S_INS_RD: if (!full && idx == '0) count <= count + 1'b1;
        S_INS_USE: if (!(rm >= sval)) count <= count + 1'b1;
        default: ;
      endcase
    end
  end

  // advance the working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        opr <= op_t'(operation);
        sval <= sample_value;
        swgt <= (sample_weight == '0) ? WGT_W'(1) : WGT_W'(sample_weight);
        pfrac <= rank_fraction;
        quantile_value <= '0;
        sample_dropped <= 1'b0;
        weighted <= 1'b1;
        limit <= thr;
        gap <= '1;
        total <= '0;
        idx <= (op_t'(operation) == OP_ADD &&
                (!full || mode == MODE_NONE || mode == MODE_RSVD)) ? count : '0;
      end
      S_GAP_USE: begin
        gap <= gap_c;
        cm <= rm;
        idx <= idx + 1'b1;
        if (last && gap_c > thr) begin
          weighted <= 1'b0;
          limit <= gap_c;
        end
      end
      S_M_LD0: begin
        cm <= rm;
        cw <= rw;
        idx <= CW'(1);
        n <= '0;
      end
      S_M_CHK: begin
        nm <= rm;
        nw <= rw;
        mean_gap <= dist_c;
        wsum <= wsum_c;
        neg <= df[DATA_W];
      end
      S_M_DIV: begin
        if (idone) begin
          cm <= mg[DATA_W-1:0];
          cw <= wsat;
        end
      end
      S_M_EMIT: begin
        n <= n + 1'b1;
        cm <= nm;
        cw <= nw;
      end
      S_M_NEXT: if (!last) idx <= idx + 1'b1;
      S_M_FIN: idx <= n + 1'b1;
      S_INS_RD: if (full) sample_dropped <= 1'b1;
      S_INS_USE: idx <= idx_m1;
      S_P_SUM: begin
        total <= total + TW'(rw);
        idx <= idx + 1'b1;
      end
      S_P_MUL: begin
        idx <= '0;
        cum <= '0;
      end
      S_P_WALK: begin
        cum <= cum_c;
        idx <= idx + 1'b1;
        if (last || hit) begin
          quantile_value <= rm;
        end
      end
      default: ;
    endcase
  end

  assign centroid_count = count;

endmodule

FILE: sv/qsc_ram.sv
module qsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/qsc_iter.sv
// Shared shift-add unit: 32 steps of multiply or divide, one multiplier bit a cycle.
// The divide forms a*b/d with a < d, so each step yields a quotient digit of 0, 1 or 2.
module qsc_iter import qsc_pkg::*; #(
  parameter int AW = 53
) (
  input  logic                 clk,
  input  logic                 rst,
  input  iter_ctl_t            ctl,
  input  logic [AW-1:0]        a,
  input  logic [STEPS-1:0]     b,
  input  logic [WGT_W:0]       d,
  output logic                 done,
  output logic [AW+STEPS-1:0]  acc,
  output logic [STEPS-1:0]     q
);

  localparam int ACCW = AW + STEPS;
  localparam int CNTW = $clog2(STEPS);

  logic                 running;
  logic                 is_div;
  logic [CNTW-1:0]      cnt;
  logic [AW-1:0]        aop;
  logic [STEPS-1:0]     bsh;
  logic [WGT_W:0]       dop;
  logic [ACCW-1:0]      t;
  logic [ACCW-1:0]      rem;
  logic [1:0]           digit;

  // shift the partial result, add the next multiplier bit, reduce by the divisor
  always_comb begin
    t = {acc[ACCW-2:0], 1'b0} + (bsh[STEPS-1] ? ACCW'(aop) : '0);
    rem = t;
    digit = 2'd0;
    if (is_div && (t >= ACCW'({dop, 1'b0}))) begin
      rem = t - ACCW'({dop, 1'b0});
      digit = 2'd2;
    end else if (is_div && (t >= ACCW'(dop))) begin
      rem = t - ACCW'(dop);
      digit = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
      end else if (running && cnt == CNTW'(STEPS - 1)) begin
        running <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // load operands, then advance one bit a cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      is_div <= ctl.is_div;
      aop <= a;
      bsh <= b;
      dop <= d;
      acc <= '0;
      q <= '0;
      cnt <= '0;
    end else if (running) begin
      acc <= rem;
      q <= {q[STEPS-2:0], 1'b0} + STEPS'(digit);
      bsh <= {bsh[STEPS-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import qsc_pkg::*;

  localparam int DEPTH = 32;
  localparam longint unsigned WGT_SAT = 64'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int ITEM_GOAL = 1400;

  // Expected result of one command
  typedef struct {
    logic signed [DATA_W-1:0] quantile;
    logic [5:0]               count;
    logic                     dropped;
  } sketch_word_t;

  // Scoreboard with its own copy of the centroid store
  class sketch_scoreboard;
    logic signed [DATA_W-1:0] mean_q[DEPTH];
    longint unsigned          weight_q[DEPTH];
    int                       held;
    longint unsigned          delta;
    logic [MODE_W-1:0]        mode;
    sketch_word_t             expected_words[$];
    int                       errors;
    int                       checked;
    int                       drops;

    function new();
      held = 0;
      delta = THR_RESET;
      mode = MODE_RESET;
      errors = 0;
      checked = 0;
      drops = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == REG_THRESHOLD) delta = value;
      else mode = value[MODE_W-1:0];
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // a + floor((b - a) * wb / w), exact
    function longint blend(longint a, longint b, longint unsigned wb, longint unsigned w);
      longint d;
      logic [127:0] num;
      logic [127:0] quo;
      logic [127:0] rem;
      d = b - a;
      num = (d < 0 ? -d : d);
      num = num * wb;
      quo = num / w;
      rem = num % w;
      if (d < 0) return a - longint'(quo) - (rem != 0 ? 1 : 0);
      return a + longint'(quo);
    endfunction

    function void merge_run(bit weighted, longint unsigned limit);
      int n;
      longint run_m;
      longint unsigned run_w;
      longint unsigned sep;
      longint unsigned sum;
      bit ok;
      if (held < 2) return;
      n = 0;
      run_m = mean_q[0];
      run_w = weight_q[0];
      for (int i = 1; i < held; i++) begin
        sep = (longint'(mean_q[i]) > run_m) ? mean_q[i] - run_m : run_m - mean_q[i];
        sum = run_w + weight_q[i];
        ok = weighted ? (sep == 0 || sum <= limit / sep) : (sep <= limit);
        if (ok) begin
          run_m = blend(run_m, mean_q[i], weight_q[i], sum);
          run_w = (sum > WGT_SAT) ? WGT_SAT : sum;
        end else begin
          mean_q[n] = DATA_W'(run_m);
          weight_q[n] = run_w;
          n++;
          run_m = mean_q[i];
          run_w = weight_q[i];
        end
      end
      mean_q[n] = DATA_W'(run_m);
      weight_q[n] = run_w;
      held = n + 1;
    endfunction

    function void merge_aggr();
      longint unsigned gap;
      longint unsigned d;
      if (held < 2) return;
      gap = '1;
      for (int i = 0; i + 1 < held; i++) begin
        d = (mean_q[i+1] > mean_q[i]) ? longint'(mean_q[i+1]) - mean_q[i]
                                      : longint'(mean_q[i]) - mean_q[i+1];
        if (d < gap) gap = d;
      end
      if (gap > delta) merge_run(1'b0, gap);
      else merge_run(1'b1, delta);
    endfunction

    function logic signed [DATA_W-1:0] rank_lookup(longint unsigned p);
      longint unsigned total;
      longint unsigned cum;
      longint unsigned target;
      if (held == 0) return '0;
      total = 0;
      cum = 0;
      for (int i = 0; i < held; i++) total += weight_q[i];
      target = p * (total >> 16) + ((p * (total & 64'hFFFF)) + 64'hFFFF) / 65536;
      for (int i = 0; i + 1 < held; i++) begin
        cum += weight_q[i];
        if (cum >= target) return mean_q[i];
      end
      return mean_q[held-1];
    endfunction

    // Note an accepted command word and queue its expected result
    function void note_command(op_t op, logic signed [31:0] value, logic [31:0] wgt,
                               logic [FRAC_W-1:0] rank);
      sketch_word_t e;
      longint unsigned w;
      int pos;
      e.quantile = '0;
      e.dropped = 1'b0;
      case (op)
        OP_ADD: begin
          w = (wgt == 0) ? 1 : wgt;
          if (held >= DEPTH) begin
            if (mode == MODE_STD) merge_run(1'b1, delta);
            else if (mode == MODE_AGGR) merge_aggr();
          end
          if (held < DEPTH) begin
            pos = 0;
            while (pos < held && mean_q[pos] < value) pos++;
            for (int i = held; i > pos; i--) begin
              mean_q[i] = mean_q[i-1];
              weight_q[i] = weight_q[i-1];
            end
            mean_q[pos] = value;
            weight_q[pos] = w;
            held++;
          end else begin
            e.dropped = 1'b1;
          end
        end
        OP_PCT: e.quantile = rank_lookup(rank);
        OP_CMP: merge_run(1'b1, delta);
        default: held = 0;
      endcase
      e.count = 6'(held);
      expected_words.push_back(e);
    endfunction

    // Compare a result word against the oldest expectation
    function void check_result(logic signed [31:0] q, logic [5:0] cnt, logic drp);
      sketch_word_t e;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result q=%0d count=%0d dropped=%0b", $time, q, cnt, drp);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      checked++;
      if (drp) drops++;
      if (q !== e.quantile) begin
        $display("%0t: quantile_value expected %0d actual %0d", $time, e.quantile, q);
        errors++;
      end
      if (cnt !== e.count) begin
        $display("%0t: centroid_count expected %0d actual %0d", $time, e.count, cnt);
        errors++;
      end
      if (drp !== e.dropped) begin
        $display("%0t: sample_dropped expected %0b actual %0b", $time, e.dropped, drp);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               operation = OP_CLR;
  logic signed [DATA_W-1:0] sample_value = '0;
  logic [DATA_W-1:0]        sample_weight = 32'd1;
  logic [FRAC_W-1:0]        rank_fraction = '0;
  logic                     done;
  logic signed [DATA_W-1:0] quantile_value;
  logic [5:0]               centroid_count;
  logic                     sample_dropped;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [2:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  sketch_scoreboard sb = new();
  int items = 0;
  int cycles = 0;

  quantile_sketch_centroids_core #(.CAPACITY(DEPTH)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .sample_value(sample_value), .sample_weight(sample_weight),
    .rank_fraction(rank_fraction), .done(done), .quantile_value(quantile_value),
    .centroid_count(centroid_count), .sample_dropped(sample_dropped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Check every result word; time out a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(quantile_value, centroid_count, sample_dropped);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // Hold start until the block has taken the word and gone idle, then note it
  task automatic issue(op_t op, logic signed [31:0] value, logic [31:0] wgt,
                       logic [FRAC_W-1:0] rank);
    operation <= op;
    sample_value <= value;
    sample_weight <= wgt;
    rank_fraction <= rank;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(op, value, wgt, rank);
    items++;
  endtask

  // Random gap after a command: mostly none, some short, a few long
  task automatic pause();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 4) : $urandom_range(20, 150);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Write a register once the block has drained
  task automatic write_reg(logic idx, logic [31:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= (idx == REG_THRESHOLD) ? 3'd0 : 3'd4;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  function automatic logic [31:0] rand_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'd0;
    if (r < 70) return $urandom_range(1, 16);
    if (r < 85) return $urandom_range(1, 65535);
    return $urandom;
  endfunction

  function automatic logic [FRAC_W-1:0] rand_rank();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 17'd0;
    if (r == 1) return 17'd65536;
    if (r < 8) return FRAC_W'($urandom_range(0, 65536));
    return FRAC_W'($urandom_range(0, 131071));
  endfunction

  initial begin
    logic [31:0] base;
    logic [31:0] span;
    int burst;
    int r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty store, extremes, zero weight, full store in none and standard mode
    issue(OP_PCT, 0, 1, 17'd65536); pause();
    issue(OP_CMP, 0, 1, 17'd0); pause();
    issue(OP_CLR, 0, 1, 17'd0); pause();
    issue(OP_ADD, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 17'd0); pause();
    issue(OP_ADD, 32'sh8000_0000, 32'd0, 17'd0); pause();
    issue(OP_ADD, 0, 32'd1, 17'd0); pause();
    issue(OP_PCT, 0, 1, 17'd0); pause();
    issue(OP_PCT, 0, 1, 17'd65536); pause();
    issue(OP_PCT, 0, 1, 17'h1FFFF); pause();
    issue(OP_CMP, 0, 1, 17'd0); pause();
    write_reg(REG_MODE, MODE_NONE);
    write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
    for (int i = 0; i < 34; i++) begin
      issue(OP_ADD, i * 1000, 2, 17'd0);
      pause();
    end
    write_reg(REG_MODE, MODE_STD);
    issue(OP_ADD, 500, 0, 17'd0); pause();
    issue(OP_PCT, 0, 1, 17'd32768); pause();
    issue(OP_CLR, 0, 1, 17'd0); pause();

    // Random phases, each under its own register setting
    while (items < ITEM_GOAL) begin
      r = $urandom_range(0, 5);
      write_reg(REG_THRESHOLD, (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF :
                               (r < 4) ? $urandom_range(0, 200000) : $urandom);
      write_reg(REG_MODE, $urandom_range(0, 3));
      issue(OP_CLR, 0, 1, 17'd0); pause();
      base = $urandom;
      span = (32'd1 << $urandom_range(0, 31)) - 1;
      burst = $urandom_range(20, 90);
      for (int i = 0; i < burst; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70) issue(OP_ADD, base + ($urandom & span), rand_weight(),
                          FRAC_W'($urandom));
        else if (r < 88) issue(OP_PCT, $urandom, $urandom, rand_rank());
        else if (r < 97) issue(OP_CMP, $urandom, $urandom, FRAC_W'($urandom));
        else issue(OP_CLR, $urandom, $urandom, FRAC_W'($urandom));
        pause();
      end
    end

    // Drain
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d commands issued, %0d results checked, %0d samples dropped",
             items, sb.checked, sb.drops);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/qsc_pkg.sv
sv/qsc_ram.sv
sv/qsc_iter.sv
sv/quantile_sketch_centroids_core.sv
tb/tb.sv
